FILE: src/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types and codes for the mesh synthetic traffic generator.
// ----------------------------------------------------------------------------
package mtg_pkg;

  localparam logic [1:0] FUNC_GEN       = 2'd0;
  localparam logic [1:0] FUNC_LOAD_SRC  = 2'd1;
  localparam logic [1:0] FUNC_LOAD_DIST = 2'd2;
  localparam logic [1:0] FUNC_NOP       = 2'd3;

  localparam logic [1:0] REG_PATTERN     = 2'd0;
  localparam logic [1:0] REG_SMALL_SHARE = 2'd1;
  localparam logic [1:0] REG_BCAST_SHARE = 2'd2;

  localparam logic [2:0] PAT_UNIFORM  = 3'd0;
  localparam logic [2:0] PAT_COMPL    = 3'd1;
  localparam logic [2:0] PAT_TRANSP   = 3'd2;
  localparam logic [2:0] PAT_NEIGHBOR = 3'd3;
  localparam logic [2:0] PAT_RENT     = 3'd4;

  localparam logic [8:0] SMALL_BYTES = 9'd112;
  localparam logic [8:0] LARGE_BYTES = 9'd496;

  typedef enum logic [1:0] {
    KIND_GEN       = 2'd0,
    KIND_LOAD_SRC  = 2'd1,
    KIND_LOAD_DIST = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [5:0]  entry_index;
    logic [15:0] entry_fraction;
    logic [5:0]  entry_node;
    logic [15:0] rnd_size;
    logic [15:0] rnd_kind;
    logic [15:0] rnd_source;
    logic [15:0] rnd_pick;
    logic [15:0] rnd_step;
    logic        rnd_north_south;
    logic        rnd_east_west;
  } item_t;

  typedef struct packed {
    logic [2:0]  pattern;
    logic [16:0] small_share;
    logic [16:0] bcast_share;
  } cfg_t;

endpackage

FILE: src/mtg_ram.sv
// ----------------------------------------------------------------------------
// mtg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mtg_ram #(
  parameter int W = 16,
  parameter int D = 64,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/mtg_front.sv
// ----------------------------------------------------------------------------
// mtg_front
// Accepts input beats, classifies them by func and queues them (2 deep); FUNC_NOP beats are dropped.
// ----------------------------------------------------------------------------
module mtg_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_func,
  input  logic [111:0]   in_data,
  output logic           q_valid,
  output mtg_pkg::item_t q_item,
  input  logic           q_pop
);

  mtg_pkg::item_t slot [2];
  logic           wptr, rptr;
  logic [1:0]     count;
  logic           push, keep;
  mtg_pkg::item_t item;

  always_comb begin
    keep = 1'b1;
    item.kind = mtg_pkg::KIND_GEN;
    unique case (in_func)
      mtg_pkg::FUNC_GEN:       item.kind = mtg_pkg::KIND_GEN;
      mtg_pkg::FUNC_LOAD_SRC:  item.kind = mtg_pkg::KIND_LOAD_SRC;
      mtg_pkg::FUNC_LOAD_DIST: item.kind = mtg_pkg::KIND_LOAD_DIST;
      default:                 keep = 1'b0;
    endcase
    item.entry_index     = in_data[5:0];
    item.entry_fraction  = in_data[21:6];
    item.entry_node      = in_data[27:22];
    item.rnd_size        = in_data[43:28];
    item.rnd_kind        = in_data[59:44];
    item.rnd_source      = in_data[75:60];
    item.rnd_pick        = in_data[91:76];
    item.rnd_step        = in_data[107:92];
    item.rnd_north_south = in_data[108];
    item.rnd_east_west   = in_data[109];
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready && keep;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wptr] <= item;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (q_pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

FILE: src/mtg_back.sv
// ----------------------------------------------------------------------------
// mtg_back
// Executes queued items: table loads, source search, destination calculation.
// ----------------------------------------------------------------------------
module mtg_back #(
  parameter int MESH_SIDE     = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  mtg_pkg::cfg_t  cfg,
  input  logic           q_valid,
  input  mtg_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [23:0]    out_data
);

  localparam int K        = MESH_SIDE;
  localparam int NODES    = K * K;
  localparam int DIST_LEN = 2 * K - 2;
  localparam int NW       = $clog2(NODES);
  localparam int DAW      = (DIST_LEN > 1) ? $clog2(DIST_LEN) : 1;
  localparam int CW       = $clog2(K);
  localparam int AW       = $clog2(2 * K) + 1;
  localparam int TW       = ((NW > 6) ? NW : 6) + 1;
  localparam int FM       = (1 << FRACTION_BITS) - 1;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SRCH  = 7'b0000010,
    ST_MOD   = 7'b0000100,
    ST_DIV   = 7'b0001000,
    ST_DIST  = 7'b0010000,
    ST_CALC1 = 7'b0100000,
    ST_CALC2 = 7'b1000000
  } state_t;

  function automatic logic [8:0] scale(input logic [15:0] r, input logic [8:0] n);
    logic [23:0] rs;
    logic [32:0] p;
    rs = (24'(r) > 24'(FM)) ? 24'(FM) : 24'(r);
    p  = 33'(rs) * 33'(n);
    return 9'(p >> FRACTION_BITS);
  endfunction

  state_t          state;
  mtg_pkg::item_t  ent;
  logic [NW-1:0]   cnt, dindex;
  logic            dv;
  logic [TW-1:0]   tmp;
  logic [NW-1:0]   src_node;
  logic [CW-1:0]   row, col;
  logic [AW-1:0]   hops;
  logic [8:0]      sc;

  logic            src_we, dist_we;
  logic [21:0]     src_rd;
  logic [15:0]     dist_rd;
  logic            bcast, rent;
  logic [NW-1:0]   src;

  assign src_we  = (state == ST_IDLE) && q_valid && q_item.kind == mtg_pkg::KIND_LOAD_SRC
                   && 9'(q_item.entry_index) < 9'(NODES);
  assign dist_we = (state == ST_IDLE) && q_valid && q_item.kind == mtg_pkg::KIND_LOAD_DIST
                   && 7'(q_item.entry_index) < 7'(DIST_LEN);
  assign q_pop   = (state == ST_IDLE) && q_valid;

  mtg_ram #(.W(22), .D(NODES)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (NW'(q_item.entry_index)),
    .wdata ({q_item.entry_node, q_item.entry_fraction}),
    .raddr (cnt),
    .rdata (src_rd)
  );

  mtg_ram #(.W(16), .D(DIST_LEN)) u_dist_ram (
    .clk   (clk),
    .we    (dist_we),
    .waddr (DAW'(q_item.entry_index)),
    .wdata (q_item.entry_fraction),
    .raddr (DAW'(cnt)),
    .rdata (dist_rd)
  );

  assign bcast = 17'(ent.rnd_kind) < cfg.bcast_share;
  assign rent  = !bcast && cfg.pattern == mtg_pkg::PAT_RENT;
  assign src   = src_node;

  // rent distance geometry
  logic [AW-1:0] mx, my, lo, hi, x, y, rsum, csum, rr, cc;
  logic          feasible;
  always_comb begin
    mx = (col < CW'(K / 2)) ? AW'(K - 1) - AW'(col) : AW'(col);
    my = (row < CW'(K / 2)) ? AW'(K - 1) - AW'(row) : AW'(row);
    feasible = (mx + my) >= hops;
    lo = (hops > my) ? hops - my : '0;
    hi = (hops < mx) ? hops : mx;
    x  = lo + AW'(sc);
    y  = hops - x;
    rsum = AW'(row) + y;
    csum = AW'(col) + x;
    if (!ent.rnd_north_south) rr = (rsum >= AW'(K)) ? AW'(row) - y : rsum;
    else                      rr = (AW'(row) < y) ? rsum : AW'(row) - y;
    if (!ent.rnd_east_west)   cc = (csum >= AW'(K)) ? AW'(col) - x : csum;
    else                      cc = (AW'(col) < x) ? csum : AW'(col) - x;
  end

  logic [8:0]    sc_n;
  logic [15:0]   sc_r;
  always_comb begin
    sc_r = ent.rnd_pick;
    if (rent) begin
      sc_r = ent.rnd_step;
      sc_n = 9'(hi - lo) + 9'd1;
    end else if (cfg.pattern == mtg_pkg::PAT_NEIGHBOR) begin
      sc_n = 9'd4;
    end else begin
      sc_n = 9'(NODES - 1);
    end
  end

  logic [NW-1:0] dst;
  logic          nodrop;
  logic [CW-1:0] nr, nc, fr, fc;
  always_comb begin
    nodrop = 1'b0;
    nr = row;
    nc = col;
    fr = (row < CW'(K / 2)) ? CW'(K - 1) : '0;
    fc = (col < CW'(K / 2)) ? CW'(K - 1) : '0;
    unique case (sc[1:0])
      2'd0:    nr = (row == CW'(K - 1)) ? row - 1'b1 : row + 1'b1;
      2'd1:    nc = (col == CW'(K - 1)) ? col - 1'b1 : col + 1'b1;
      2'd2:    nr = (row == '0) ? row + 1'b1 : row - 1'b1;
      default: nc = (col == '0) ? col + 1'b1 : col - 1'b1;
    endcase
    if (bcast) begin
      dst = NW'(NW'(fr) * NW'(K) + NW'(fc));
    end else begin
      unique case (cfg.pattern)
        mtg_pkg::PAT_COMPL:    dst = NW'(NODES - 1) - src;
        mtg_pkg::PAT_TRANSP:   dst = NW'(NW'(col) * NW'(K) + NW'(row));
        mtg_pkg::PAT_NEIGHBOR: dst = NW'(NW'(nr) * NW'(K) + NW'(nc));
        mtg_pkg::PAT_RENT: begin
          if (!feasible) begin
            nodrop = 1'b1;
            dst    = '0;
          end else begin
            dst = NW'(NW'(rr) * NW'(K) + NW'(cc));
          end
        end
        default: dst = (NW'(sc) >= src) ? NW'(sc) + 1'b1 : NW'(sc);
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && q_valid && q_item.kind == mtg_pkg::KIND_GEN) begin
      ent <= q_item;
    end
    dindex <= cnt;
    unique case (state)
      ST_SRCH:  if (dv) tmp <= TW'(src_rd[21:16]);
      ST_MOD:   if (tmp >= TW'(NODES)) tmp <= tmp - TW'(NODES);
      ST_DIST:  if (dv) hops <= AW'(dindex) + 1'b1;
      ST_CALC1: sc <= scale(sc_r, sc_n);
      default: ;
    endcase
    if (state == ST_MOD) src_node <= NW'(tmp);
    if (state == ST_SRCH || state == ST_DIST) begin
      if (cnt != NW'(NODES - 1)) cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
    if (state == ST_MOD) begin
      row <= '0;
    end else if (state == ST_DIV && tmp >= TW'(K)) begin
      row <= row + 1'b1;
    end
    if (state == ST_DIV) col <= CW'(tmp);
    if (state == ST_DIV && tmp >= TW'(K)) tmp <= tmp - TW'(K);
    if (state == ST_CALC2 && (!out_valid || out_ready)) begin
      out_data <= {1'b0, nodrop, bcast,
                   (17'(ent.rnd_size) < cfg.small_share) ? mtg_pkg::SMALL_BYTES
                                                         : mtg_pkg::LARGE_BYTES,
                   6'(dst), 6'(src)};
    end
    if (rst) begin
      state     <= ST_IDLE;
      dv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_CALC2 && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      dv <= (state == ST_SRCH || state == ST_DIST);
      unique case (state)
        ST_IDLE: if (q_valid && q_item.kind == mtg_pkg::KIND_GEN) state <= ST_SRCH;
        ST_SRCH: begin
          if (dv && (ent.rnd_source <= src_rd[15:0] || dindex == NW'(NODES - 1))) begin
            state <= ST_MOD;
          end
        end
        ST_MOD: if (tmp < TW'(NODES)) state <= ST_DIV;
        ST_DIV: if (tmp < TW'(K)) state <= rent ? ST_DIST : ST_CALC1;
        ST_DIST: begin
          if (dv && (ent.rnd_pick <= dist_rd || dindex == NW'(DIST_LEN - 1))) begin
            state <= ST_CALC1;
          end
        end
        ST_CALC1: state <= ST_CALC2;
        ST_CALC2: begin
          if (!out_valid || out_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/mesh_synthetic_traffic_generator.sv
// ----------------------------------------------------------------------------
// mesh_synthetic_traffic_generator
// Packet descriptor generator for a square mesh with loadable CDF tables.
//
//   channel  direction  contents
//   s_*      in         tuser: func; tdata: load entry and random fractions
//   m_*      out        tdata: descriptor
//   cfg_*    in         register writes (pattern, small_share, bcast_share)
//
// Load beats are written to their table directly from idle. A generate beat runs
// a source search, reduces the matched node modulo NODES, splits it into row and
// column by MESH_SIDE, adds a distance search for non-broadcast rent descriptors
// and then computes the destination; the searches read one RAM entry per cycle.
// Reset is synchronous and clears control only.
// A stalled output holds one descriptor, a finished one waits behind it and
// two more beats can queue.
// ----------------------------------------------------------------------------
module mesh_synthetic_traffic_generator #(
  parameter int MESH_SIDE     = 8,
  parameter int FRACTION_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index, entry_fraction, entry_node, rnd_size, rnd_kind, rnd_source,
  // rnd_pick, rnd_step, rnd_north_south, rnd_east_west, zero fill
  input  logic [111:0] s_tdata,
  // func
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // source_node, dest_node, payload_bytes, is_broadcast, no_destination, zero fill
  output logic [23:0]  m_tdata,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [16:0]  cfg_data
);

  mtg_pkg::cfg_t  cfg;
  logic           q_valid, q_pop;
  mtg_pkg::item_t q_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern     <= mtg_pkg::PAT_UNIFORM;
      cfg.small_share <= 17'd32768;
      cfg.bcast_share <= 17'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtg_pkg::REG_PATTERN:     cfg.pattern     <= cfg_data[2:0];
        mtg_pkg::REG_SMALL_SHARE: cfg.small_share <= cfg_data;
        mtg_pkg::REG_BCAST_SHARE: cfg.bcast_share <= cfg_data;
        default: ;
      endcase
    end
  end

  mtg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_func  (s_tuser),
    .in_data  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  mtg_back #(
    .MESH_SIDE     (MESH_SIDE),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule
